// ===== design/double_ended_queue_unit_defines.svh =====
// Assertion macros for the double-ended queue unit.
// Used by double_ended_queue_unit.sv; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// Shared types and codes for the double-ended queue unit.
// No dependencies; imported by deq_mem, deq_ctrl and the top level.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_LIST       = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_REMOVED = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_LISTED  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  item;
        logic                      last;
    } t_res;

endpackage

// ===== design/deq_mem.sv =====
// Entry storage: one write port, one read port, registered read data.
// Depends on deq_pkg for the word width.
`timescale 1ns / 1ps

module deq_mem
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WORD_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/deq_ctrl.sv =====
// Queue control: head pointer, occupancy, request decode and list sequencing.
// Depends on deq_pkg; drives the deq_mem ports.
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_mode,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_res_valid,
    output t_res                     o_res,
    input  logic                     i_res_ready,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [WORD_W-1:0]        o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [WORD_W-1:0]        i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state         r_state, n_state;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [CW-1:0]  r_left, n_left;
    logic           r_pop, n_pop;

    t_mode          mode;
    logic           accept;
    logic           full;
    logic           empty;
    logic [AW-1:0]  head_inc;
    logic [AW-1:0]  head_dec;
    logic [AW-1:0]  tail_slot;
    logic [AW-1:0]  back_slot;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        if (s >= (AW+1)'(DEPTH)) begin
            return AW'(s - (AW+1)'(DEPTH));
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign mode      = t_mode'(i_mode);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_inc  = inc(r_head);
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign tail_slot = wrap({1'b0, r_head} + (AW+1)'(r_count));
    assign back_slot = wrap({1'b0, r_head} + (AW+1)'(r_count - 1'b1));

    assign o_ready = (r_state == S_IDLE) && i_res_ready;
    assign accept  = i_valid && o_ready;
    assign o_wdata = i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_left  <= n_left;
            r_pop   <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_pop       = r_pop;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_STORED, item: '0, last: 1'b1};
        o_we        = 1'b0;
        o_waddr     = r_head;
        o_re        = 1'b0;
        o_raddr     = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (mode) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            o_res_valid = 1'b1;
                            if (full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + 1'b1;
                                if (mode == MODE_PUSH_FRONT) begin
                                    o_waddr = head_dec;
                                    n_head  = head_dec;
                                end else begin
                                    o_waddr = tail_slot;
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK, MODE_LIST: begin
                            if (empty) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                o_re    = 1'b1;
                                n_state = S_DATA;
                                n_pop   = (mode != MODE_LIST);
                                n_ptr   = head_inc;
                                if (mode == MODE_LIST) begin
                                    n_left = r_count;
                                end else begin
                                    n_left  = CW'(1);
                                    n_count = r_count - 1'b1;
                                end
                                if (mode == MODE_POP_FRONT) begin
                                    n_head = head_inc;
                                end
                                if (mode == MODE_POP_BACK) begin
                                    o_raddr = back_slot;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DATA: begin
                o_res_valid  = 1'b1;
                o_res.status = r_pop ? ST_REMOVED : ST_LISTED;
                o_res.item   = i_rdata;
                o_res.last   = (r_left == CW'(1));
                if (i_res_ready) begin
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_ptr;
                        n_ptr   = inc(r_ptr);
                        n_left  = r_left - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/double_ended_queue_unit.sv =====
// Double-ended queue unit: top level with the output register.
// Depends on deq_pkg, deq_mem, deq_ctrl and double_ended_queue_unit_defines.svh.
//
// Usage:
//   Requests enter on i_valid/o_ready with i_mode and i_value; results leave
//   on o_valid/i_ready with o_status, o_item and o_last. o_last marks the
//   final result of each request. Modes 5 to 7 give no result.
//   Pushes: the result is in the output register in the cycle after the
//   request is taken; one request per cycle while the output side is ready.
//   Pops: the entry is read into the memory's read register first and then
//   passes to the output register; the next request is taken once the
//   result has moved into the output register.
//   List: after the first entry is read from the memory, one listed entry
//   per cycle while the output side is ready; the last one carries o_last.
//   The single memory read port sets the pace of pops and lists.
//   Reset (i_rst_n low, synchronous) empties the queue and the output
//   register. While i_ready is low the output holds and o_ready drops as
//   soon as a new result has nowhere to go.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_mode,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_status,
    output logic signed [WORD_W-1:0] o_item,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    t_res              res;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;

    logic              r_out_valid;
    t_res              r_out;

    deq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    deq_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out.status;
    assign o_item   = r_out.item;
    assign o_last   = r_out.last;

    `DEQ_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, res_valid && !res_ready, res_valid && (res == $past(res)), "stalled result changed")
    `DEQ_ASSERT_IMPL(a_no_take_when_blocked, i_clk, i_rst_n, r_out_valid && !i_ready, !o_ready, "request taken while output blocked")
    `DEQ_ASSERT_NEXT(a_push_answers, i_clk, i_rst_n, i_valid && o_ready && (i_mode == MODE_PUSH_FRONT || i_mode == MODE_PUSH_BACK), r_out_valid && r_out.last, "push gave no result")

endmodule
